// ----- src/rrqs_pkg.sv -----
// Shared constants, types and helpers for the ready-queue scheduler.
// No dependencies; every other file uses these by scoped name.
package rrqs_pkg;

  localparam int QUEUE_DEPTH = 16;
  localparam int IDX_W       = $clog2(QUEUE_DEPTH);
  localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);

  localparam int ID_W    = 16;
  localparam int BURST_W = 16;
  localparam int PRIO_W  = 4;
  localparam int TIME_W  = 32;
  localparam int DONE_W  = 16;
  localparam int STAT_W  = 2;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 16;

  localparam logic [PRIO_W-1:0] PRIO_HIGH   = 4'd1;
  localparam logic [PRIO_W-1:0] PRIO_NORMAL = 4'd5;
  localparam logic [PRIO_W-1:0] PRIO_LOW    = 4'd10;
  localparam logic [ID_W-1:0]   FIRST_ID    = 16'd100;
  localparam logic [BURST_W-1:0] QUANTUM_RST = 16'd5;

  localparam logic REQ_INSERT   = 1'b0;
  localparam logic REQ_DISPATCH = 1'b1;

  localparam logic [STAT_W-1:0] STAT_OK      = 2'd0;
  localparam logic [STAT_W-1:0] STAT_EMPTY   = 2'd1;
  localparam logic [STAT_W-1:0] STAT_FULL    = 2'd2;
  localparam logic [STAT_W-1:0] STAT_BADPRIO = 2'd3;

  localparam logic [CFG_IDX_W-1:0] CFG_QUANTUM = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_RTC     = 1'd1;

  typedef struct packed {
    logic [ID_W-1:0]    id;
    logic [BURST_W-1:0] remaining;
    logic [TIME_W-1:0]  time_mark;
    logic [TIME_W-1:0]  wait_acc;
    logic               seen;
  } slot_t;

  function automatic logic [TIME_W-1:0] sat_add32(logic [TIME_W-1:0] a,
                                                  logic [TIME_W-1:0] b);
    logic [TIME_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[TIME_W] ? {TIME_W{1'b1}} : s[TIME_W-1:0];
  endfunction

  // Slot at base + offs around the ring; offs never exceeds the depth.
  function automatic logic [IDX_W-1:0] ring_index(logic [IDX_W-1:0] base,
                                                  logic [CNT_W-1:0] offs);
    logic [CNT_W:0] s;
    s = {{(CNT_W + 1 - IDX_W){1'b0}}, base} + {1'b0, offs};
    if (s >= (CNT_W + 1)'(QUEUE_DEPTH)) begin
      s = s - (CNT_W + 1)'(QUEUE_DEPTH);
    end
    return s[IDX_W-1:0];
  endfunction

endpackage

// ----- src/rrqs_if.sv -----
// Valid/ready channel interfaces for scheduler requests and results.
// Depends on rrqs_pkg for field widths.
interface rrqs_req_if;
  logic                         valid;
  logic                         ready;
  logic                         req_type;
  logic [rrqs_pkg::BURST_W-1:0] burst;
  logic [rrqs_pkg::PRIO_W-1:0]  priority_req;
  modport source (output valid, req_type, burst, priority_req, input ready);
  modport sink   (input valid, req_type, burst, priority_req, output ready);
endinterface

interface rrqs_rsp_if;
  logic                         valid;
  logic                         ready;
  logic [rrqs_pkg::ID_W-1:0]    process_id;
  logic [rrqs_pkg::STAT_W-1:0]  status;
  logic [rrqs_pkg::BURST_W-1:0] ran_for;
  logic [rrqs_pkg::TIME_W-1:0]  waited_now;
  logic [rrqs_pkg::TIME_W-1:0]  process_wait;
  logic [rrqs_pkg::TIME_W-1:0]  clock_now;
  logic [rrqs_pkg::TIME_W-1:0]  total_wait;
  logic [rrqs_pkg::DONE_W-1:0]  finished_count;
  logic                         completed;
  modport source (output valid, process_id, status, ran_for, waited_now, process_wait,
                  clock_now, total_wait, finished_count, completed, input ready);
  modport sink   (input valid, process_id, status, ran_for, waited_now, process_wait,
                  clock_now, total_wait, finished_count, completed, output ready);
endinterface

// ----- src/rrqs_slot_ram.sv -----
// Ready-queue slot store: one write port, one read port, registered read data.
// Depends on rrqs_pkg for slot_t and the queue depth.
module rrqs_slot_ram (
  input  logic                       clk,
  input  logic                       wr_en,
  input  logic [rrqs_pkg::IDX_W-1:0] wr_addr,
  input  rrqs_pkg::slot_t            wr_data,
  input  logic [rrqs_pkg::IDX_W-1:0] rd_addr,
  output rrqs_pkg::slot_t            rd_data
);

  rrqs_pkg::slot_t mem [rrqs_pkg::QUEUE_DEPTH];
  rrqs_pkg::slot_t rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

// ----- src/round_robin_ready_queue_scheduler_core.sv -----
// Round-robin ready-queue scheduler: ring of process slots in rrqs_slot_ram,
// queue pointers, clock and totals in flip-flops. Depends on rrqs_pkg, rrqs_if.
//
//  channel  | dir | handshake              | payload
//  ---------+-----+------------------------+------------------------------------
//  in_ch    | in  | valid/ready            | req_type, burst, priority_req
//  out_ch   | out | valid/ready            | process_id .. completed (one/item)
//  cfg_*    | in  | cfg_we, no back-press  | cfg_index, cfg_data
//
// An insert is handled in the idle state; a dispatch moves on to ST_DISP, which uses the
// registered read of the head slot from the slot RAM before any write-back to the tail.
// A new transaction is taken only while the output register is free or drains
// in the same cycle, so a stalled result holds the input side.
// Reset clears pointers, clock and totals; slot contents stay undefined and are
// read only after being written.
module round_robin_ready_queue_scheduler_core (
  input  logic                            clk,
  input  logic                            rst_n,
  rrqs_req_if.sink                        in_ch,
  rrqs_rsp_if.source                      out_ch,
  input  logic                            cfg_we,
  input  logic [rrqs_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [rrqs_pkg::CFG_DATA_W-1:0] cfg_data
);

  typedef enum logic {ST_IDLE, ST_DISP} state_t;

  typedef struct packed {
    logic [rrqs_pkg::ID_W-1:0]    process_id;
    logic [rrqs_pkg::STAT_W-1:0]  status;
    logic [rrqs_pkg::BURST_W-1:0] ran_for;
    logic [rrqs_pkg::TIME_W-1:0]  waited_now;
    logic [rrqs_pkg::TIME_W-1:0]  process_wait;
    logic [rrqs_pkg::TIME_W-1:0]  clock_now;
    logic [rrqs_pkg::TIME_W-1:0]  total_wait;
    logic [rrqs_pkg::DONE_W-1:0]  finished_count;
    logic                         completed;
  } rsp_t;

  state_t                       state_r, state_nxt;
  logic [rrqs_pkg::IDX_W-1:0]   head_r, head_nxt;
  logic [rrqs_pkg::CNT_W-1:0]   count_r, count_nxt;
  logic [rrqs_pkg::ID_W-1:0]    next_id_r, next_id_nxt;
  logic [rrqs_pkg::TIME_W-1:0]  clock_r, clock_nxt;
  logic [rrqs_pkg::TIME_W-1:0]  wait_sum_r, wait_sum_nxt;
  logic [rrqs_pkg::DONE_W-1:0]  done_r, done_nxt;
  logic [rrqs_pkg::BURST_W-1:0] quantum_r;
  logic                         rtc_r;
  logic                         out_valid_r, out_valid_nxt;
  rsp_t                         out_r, out_nxt;

  logic                         accept;
  logic                         prio_ok;
  logic                         mem_we;
  logic [rrqs_pkg::IDX_W-1:0]   mem_waddr;
  rrqs_pkg::slot_t              mem_wdata;
  rrqs_pkg::slot_t              mem_rdata;
  logic [rrqs_pkg::ID_W-1:0]    id_inc;
  logic [rrqs_pkg::TIME_W-1:0]  waited;
  logic [rrqs_pkg::TIME_W-1:0]  pwait;
  logic [rrqs_pkg::BURST_W-1:0] ran;
  logic                         finish;

  // Head is stable from accept until the slot data returns, so read it always.
  // Writes and reads never fall in the same cycle for one transaction pair.
  rrqs_slot_ram u_slot_ram (
    .clk     (clk),
    .wr_en   (mem_we),
    .wr_addr (mem_waddr),
    .wr_data (mem_wdata),
    .rd_addr (head_r),
    .rd_data (mem_rdata)
  );

  assign in_ch.ready = (state_r == ST_IDLE) && (!out_valid_r || out_ch.ready);
  assign accept      = in_ch.valid && in_ch.ready;
  assign prio_ok     = (in_ch.priority_req == rrqs_pkg::PRIO_HIGH)   ||
                       (in_ch.priority_req == rrqs_pkg::PRIO_NORMAL) ||
                       (in_ch.priority_req == rrqs_pkg::PRIO_LOW);
  assign id_inc      = next_id_r + 1'b1;

  always_comb begin
    waited = (clock_r >= mem_rdata.time_mark) ? clock_r - mem_rdata.time_mark : '0;
    pwait  = mem_rdata.seen ? rrqs_pkg::sat_add32(mem_rdata.wait_acc, waited) : waited;
    finish = rtc_r || (mem_rdata.remaining <= quantum_r);
    ran    = finish ? mem_rdata.remaining : quantum_r;
  end

  always_comb begin
    state_nxt     = state_r;
    head_nxt      = head_r;
    count_nxt     = count_r;
    next_id_nxt   = next_id_r;
    clock_nxt     = clock_r;
    wait_sum_nxt  = wait_sum_r;
    done_nxt      = done_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    out_nxt       = out_r;
    mem_we        = 1'b0;
    mem_waddr     = '0;
    mem_wdata     = '0;

    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          out_nxt                = '0;
          out_nxt.clock_now      = clock_r;
          out_nxt.total_wait     = wait_sum_r;
          out_nxt.finished_count = done_r;
          if (in_ch.req_type == rrqs_pkg::REQ_INSERT) begin
            out_valid_nxt = 1'b1;
            if (!prio_ok) begin
              // burn a number, queue nothing
              next_id_nxt        = id_inc;
              out_nxt.process_id = id_inc;
              out_nxt.status     = rrqs_pkg::STAT_BADPRIO;
            end else if (count_r == rrqs_pkg::CNT_W'(rrqs_pkg::QUEUE_DEPTH)) begin
              out_nxt.status = rrqs_pkg::STAT_FULL;
            end else begin
              next_id_nxt         = id_inc;
              out_nxt.process_id  = id_inc;
              out_nxt.status      = rrqs_pkg::STAT_OK;
              count_nxt           = count_r + 1'b1;
              mem_we              = 1'b1;
              mem_wdata.id        = id_inc;
              mem_wdata.remaining = in_ch.burst;
              mem_wdata.time_mark = clock_r;
              if (in_ch.priority_req == rrqs_pkg::PRIO_HIGH) begin
                head_nxt  = (head_r == '0) ? rrqs_pkg::IDX_W'(rrqs_pkg::QUEUE_DEPTH - 1)
                                           : head_r - 1'b1;
                mem_waddr = head_nxt;
              end else begin
                mem_waddr = rrqs_pkg::ring_index(head_r, count_r);
              end
            end
          end else if (count_r == '0) begin
            out_valid_nxt  = 1'b1;
            out_nxt.status = rrqs_pkg::STAT_EMPTY;
          end else begin
            state_nxt = ST_DISP;
          end
        end
      end
      ST_DISP: begin
        state_nxt    = ST_IDLE;
        clock_nxt    = rrqs_pkg::sat_add32(clock_r, rrqs_pkg::TIME_W'(ran));
        wait_sum_nxt = rrqs_pkg::sat_add32(wait_sum_r, waited);
        head_nxt     = (head_r == rrqs_pkg::IDX_W'(rrqs_pkg::QUEUE_DEPTH - 1))
                       ? '0 : head_r + 1'b1;
        if (finish) begin
          count_nxt = count_r - 1'b1;
          if (done_r != {rrqs_pkg::DONE_W{1'b1}}) begin
            done_nxt = done_r + 1'b1;
          end
        end else begin
          // requeue at the tail; the popped slot counts as free here
          mem_we              = 1'b1;
          mem_waddr           = rrqs_pkg::ring_index(head_r, count_r);
          mem_wdata.id        = mem_rdata.id;
          mem_wdata.remaining = mem_rdata.remaining - ran;
          mem_wdata.time_mark = clock_nxt;
          mem_wdata.wait_acc  = pwait;
          mem_wdata.seen      = 1'b1;
        end
        out_valid_nxt          = 1'b1;
        out_nxt.process_id     = mem_rdata.id;
        out_nxt.status         = rrqs_pkg::STAT_OK;
        out_nxt.ran_for        = ran;
        out_nxt.waited_now     = waited;
        out_nxt.process_wait   = pwait;
        out_nxt.clock_now      = clock_nxt;
        out_nxt.total_wait     = wait_sum_nxt;
        out_nxt.finished_count = done_nxt;
        out_nxt.completed      = finish;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      head_r      <= '0;
      count_r     <= '0;
      next_id_r   <= rrqs_pkg::FIRST_ID;
      clock_r     <= '0;
      wait_sum_r  <= '0;
      done_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      head_r      <= head_nxt;
      count_r     <= count_nxt;
      next_id_r   <= next_id_nxt;
      clock_r     <= clock_nxt;
      wait_sum_r  <= wait_sum_nxt;
      done_r      <= done_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_r <= out_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      quantum_r <= rrqs_pkg::QUANTUM_RST;
      rtc_r     <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        rrqs_pkg::CFG_QUANTUM: quantum_r <= cfg_data;
        rrqs_pkg::CFG_RTC:     rtc_r     <= cfg_data[0];
        default: ;
      endcase
    end
  end

  assign out_ch.valid          = out_valid_r;
  assign out_ch.process_id     = out_r.process_id;
  assign out_ch.status         = out_r.status;
  assign out_ch.ran_for        = out_r.ran_for;
  assign out_ch.waited_now     = out_r.waited_now;
  assign out_ch.process_wait   = out_r.process_wait;
  assign out_ch.clock_now      = out_r.clock_now;
  assign out_ch.total_wait     = out_r.total_wait;
  assign out_ch.finished_count = out_r.finished_count;
  assign out_ch.completed      = out_r.completed;

endmodule

// ----- src/rrqs_checker.sv -----
// Port-level checks for the ready-queue scheduler, bound to the top level.
// Depends on rrqs_pkg for status codes.
module rrqs_checker (
  input logic                         clk,
  input logic                         rst_n,
  input logic                         out_valid,
  input logic                         out_ready,
  input logic [rrqs_pkg::ID_W-1:0]    process_id,
  input logic [rrqs_pkg::STAT_W-1:0]  status,
  input logic [rrqs_pkg::BURST_W-1:0] ran_for,
  input logic [rrqs_pkg::DONE_W-1:0]  finished_count,
  input logic                         completed
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(process_id) && $stable(status))
    else $error("result dropped or changed while stalled");

  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  a_empty_blank: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && status == rrqs_pkg::STAT_EMPTY |->
      process_id == '0 && ran_for == '0 && !completed)
    else $error("empty-queue result carries process data");

  a_done_counted: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && completed |-> status == rrqs_pkg::STAT_OK && finished_count != '0)
    else $error("completion without ok status or count");

endmodule

bind round_robin_ready_queue_scheduler_core rrqs_checker u_rrqs_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .out_valid      (out_ch.valid),
  .out_ready      (out_ch.ready),
  .process_id     (out_ch.process_id),
  .status         (out_ch.status),
  .ran_for        (out_ch.ran_for),
  .finished_count (out_ch.finished_count),
  .completed      (out_ch.completed)
);

// ----- tb/sv/round_robin_ready_queue_scheduler_core_test.sv -----
`timescale 1ns / 100ps
// Self-checking test of the round-robin ready-queue scheduler: a clocked driver and
// monitor around the core, with a cycle-free predictor of every result.
// Depends on rrqs_pkg, rrqs_if and round_robin_ready_queue_scheduler_core.
module round_robin_ready_queue_scheduler_core_test;

  localparam int STALL_LIMIT = 500;
  localparam int PHASE_ITEMS = 200;
  localparam int TAIL_PAIRS  = 40;

  typedef struct packed {
    logic                         req_type;
    logic [rrqs_pkg::BURST_W-1:0] burst;
    logic [rrqs_pkg::PRIO_W-1:0]  prio;
  } sched_req_t;

  typedef struct packed {
    logic [rrqs_pkg::ID_W-1:0]    process_id;
    logic [rrqs_pkg::STAT_W-1:0]  status;
    logic [rrqs_pkg::BURST_W-1:0] ran_for;
    logic [rrqs_pkg::TIME_W-1:0]  waited_now;
    logic [rrqs_pkg::TIME_W-1:0]  process_wait;
    logic [rrqs_pkg::TIME_W-1:0]  clock_now;
    logic [rrqs_pkg::TIME_W-1:0]  total_wait;
    logic [rrqs_pkg::DONE_W-1:0]  finished_count;
    logic                         completed;
  } sched_rsp_t;

  logic                            clk;
  logic                            rst_n;
  logic                            cfg_we;
  logic [rrqs_pkg::CFG_IDX_W-1:0]  cfg_index;
  logic [rrqs_pkg::CFG_DATA_W-1:0] cfg_data;

  rrqs_req_if req_ch ();
  rrqs_rsp_if rsp_ch ();

  round_robin_ready_queue_scheduler_core i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (req_ch),
    .out_ch    (rsp_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // Predicted scheduler state and settings
  rrqs_pkg::slot_t              ring_m [rrqs_pkg::QUEUE_DEPTH];
  int                           head_m;
  int                           count_m;
  logic [rrqs_pkg::ID_W-1:0]    next_id_m;
  logic [rrqs_pkg::TIME_W-1:0]  clock_m;
  logic [rrqs_pkg::TIME_W-1:0]  wait_sum_m;
  logic [rrqs_pkg::DONE_W-1:0]  done_m;
  logic [rrqs_pkg::BURST_W-1:0] quantum_m;
  logic                         rtc_m;

  sched_req_t requests_todo [$];
  sched_rsp_t results_due [$];
  sched_req_t next_rq;
  sched_req_t seen_rq;
  sched_rsp_t due;

  int   issued;
  int   taken;
  int   result_no;
  int   mismatches;
  int   stall_cycles;
  int   src_gap;
  int   sink_gap;
  bit   idling;
  logic in_taken;

  always begin
    clk = 1'b1;
    #4;
    clk = 1'b0;
    #4;
  end

  function automatic logic [rrqs_pkg::TIME_W-1:0] clamp_add32(
      logic [rrqs_pkg::TIME_W-1:0] a, logic [rrqs_pkg::TIME_W-1:0] b);
    logic [rrqs_pkg::TIME_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[rrqs_pkg::TIME_W] ? {rrqs_pkg::TIME_W{1'b1}} : s[rrqs_pkg::TIME_W-1:0];
  endfunction

  // Advance the predicted scheduler by one transaction and return its result.
  function automatic sched_rsp_t schedule_step(sched_req_t rq);
    sched_rsp_t                  r;
    rrqs_pkg::slot_t             s;
    int                          pos;
    logic [rrqs_pkg::TIME_W-1:0] waited;
    r = '0;
    if (rq.req_type == rrqs_pkg::REQ_INSERT) begin
      if (rq.prio != rrqs_pkg::PRIO_HIGH && rq.prio != rrqs_pkg::PRIO_NORMAL &&
          rq.prio != rrqs_pkg::PRIO_LOW) begin
        // an unknown priority still burns a process number, even when full
        next_id_m = next_id_m + 1'b1;
        r.process_id = next_id_m;
        r.status = rrqs_pkg::STAT_BADPRIO;
      end else if (count_m >= rrqs_pkg::QUEUE_DEPTH) begin
        r.status = rrqs_pkg::STAT_FULL;
      end else begin
        next_id_m = next_id_m + 1'b1;
        r.process_id = next_id_m;
        if (rq.prio == rrqs_pkg::PRIO_HIGH) begin
          head_m = (head_m + rrqs_pkg::QUEUE_DEPTH - 1) % rrqs_pkg::QUEUE_DEPTH;
          pos = head_m;
        end else begin
          pos = (head_m + count_m) % rrqs_pkg::QUEUE_DEPTH;
        end
        ring_m[pos] = '{id: next_id_m, remaining: rq.burst, time_mark: clock_m,
                        wait_acc: '0, seen: 1'b0};
        count_m++;
      end
    end else if (count_m == 0) begin
      r.status = rrqs_pkg::STAT_EMPTY;
    end else begin
      s = ring_m[head_m];
      r.process_id = s.id;
      waited = (clock_m >= s.time_mark) ? clock_m - s.time_mark : '0;
      r.waited_now = waited;
      r.process_wait = s.seen ? clamp_add32(s.wait_acc, waited) : waited;
      wait_sum_m = clamp_add32(wait_sum_m, waited);
      head_m = (head_m + 1) % rrqs_pkg::QUEUE_DEPTH;
      count_m--;
      if (rtc_m || s.remaining <= quantum_m) begin
        r.ran_for = s.remaining;
        r.completed = 1'b1;
        clock_m = clamp_add32(clock_m, rrqs_pkg::TIME_W'(s.remaining));
        if (done_m != {rrqs_pkg::DONE_W{1'b1}}) begin
          done_m = done_m + 1'b1;
        end
      end else begin
        // run one quantum and requeue the rest at the tail
        r.ran_for = quantum_m;
        clock_m = clamp_add32(clock_m, rrqs_pkg::TIME_W'(quantum_m));
        pos = (head_m + count_m) % rrqs_pkg::QUEUE_DEPTH;
        ring_m[pos] = '{id: s.id, remaining: s.remaining - quantum_m, time_mark: clock_m,
                        wait_acc: r.process_wait, seen: 1'b1};
        count_m++;
      end
    end
    r.clock_now = clock_m;
    r.total_wait = wait_sum_m;
    r.finished_count = done_m;
    return r;
  endfunction

  task automatic flag_mismatch(string msg);
    $display("%0t mismatch: %s", $realtime, msg);
    mismatches++;
  endtask

  task automatic check_field(string name, logic [rrqs_pkg::TIME_W-1:0] got,
                             logic [rrqs_pkg::TIME_W-1:0] want);
    if (got !== want) begin
      flag_mismatch($sformatf("result %0d %s got %0d want %0d", result_no, name, got, want));
    end
  endtask

  task automatic push_req(logic rt, logic [rrqs_pkg::BURST_W-1:0] b,
                          logic [rrqs_pkg::PRIO_W-1:0] p);
    requests_todo.push_back('{req_type: rt, burst: b, prio: p});
    issued++;
  endtask

  function automatic logic [rrqs_pkg::BURST_W-1:0] pick_burst();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return '1;
      2, 3:    return rrqs_pkg::BURST_W'($urandom);
      default: return rrqs_pkg::BURST_W'($urandom_range(1, 24));
    endcase
  endfunction

  function automatic logic [rrqs_pkg::PRIO_W-1:0] pick_prio();
    case ($urandom_range(0, 7))
      0, 1:    return rrqs_pkg::PRIO_HIGH;
      2, 3, 6: return rrqs_pkg::PRIO_NORMAL;
      4, 7:    return rrqs_pkg::PRIO_LOW;
      default: return rrqs_pkg::PRIO_W'($urandom_range(0, 15));
    endcase
  endfunction

  // Chunks that fill, drain or mix, so the queue swings between empty and full.
  task automatic random_phase(int n_items);
    int left;
    int chunk;
    int ins_pct;
    left = n_items;
    while (left > 0) begin
      chunk = $urandom_range(8, 30);
      if (chunk > left) begin
        chunk = left;
      end
      case ($urandom_range(0, 2))
        0:       ins_pct = 90;
        1:       ins_pct = 10;
        default: ins_pct = $urandom_range(30, 70);
      endcase
      repeat (chunk) begin
        if ($urandom_range(0, 99) < ins_pct) begin
          push_req(rrqs_pkg::REQ_INSERT, pick_burst(), pick_prio());
        end else begin
          push_req(rrqs_pkg::REQ_DISPATCH, rrqs_pkg::BURST_W'($urandom),
                   rrqs_pkg::PRIO_W'($urandom));
        end
      end
      left -= chunk;
    end
  endtask

  task automatic wait_drained();
    while (taken != issued || results_due.size() != 0) begin
      @(negedge clk);
    end
  endtask

  task automatic write_settings(logic [rrqs_pkg::BURST_W-1:0] q, logic rtc);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= rrqs_pkg::CFG_QUANTUM;
    cfg_data  <= rrqs_pkg::CFG_DATA_W'(q);
    quantum_m = q;
    @(negedge clk);
    cfg_index <= rrqs_pkg::CFG_RTC;
    cfg_data  <= rrqs_pkg::CFG_DATA_W'(rtc);
    rtc_m = rtc;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // Driver: hold a transaction until taken, then present the next one or idle.
  always @(negedge clk) begin
    if (rst_n !== 1'b1) begin
      req_ch.valid <= 1'b0;
      src_gap <= 0;
    end else if (!req_ch.valid || in_taken) begin
      if (src_gap > 0) begin
        src_gap <= src_gap - 1;
        req_ch.valid <= 1'b0;
      end else if (requests_todo.size() != 0) begin
        next_rq = requests_todo.pop_front();
        req_ch.req_type     <= next_rq.req_type;
        req_ch.burst        <= next_rq.burst;
        req_ch.priority_req <= next_rq.prio;
        req_ch.valid        <= 1'b1;
        if (idling && $urandom_range(0, 5) == 0) begin
          src_gap <= $urandom_range(1, 12);
        end
      end else begin
        req_ch.valid <= 1'b0;
      end
    end
  end

  // Result side back-pressure
  always @(negedge clk) begin
    if (rst_n !== 1'b1) begin
      rsp_ch.ready <= 1'b0;
      sink_gap <= 0;
    end else if (sink_gap > 0) begin
      rsp_ch.ready <= 1'b0;
      sink_gap <= sink_gap - 1;
    end else begin
      rsp_ch.ready <= 1'b1;
      if (idling && $urandom_range(0, 6) == 0) begin
        sink_gap <= $urandom_range(1, 12);
      end
    end
  end

  // Monitor: check results first, then predict for the transaction taken now.
  always @(posedge clk) begin
    if (rst_n === 1'b1) begin
      if (rsp_ch.valid && rsp_ch.ready) begin
        if (results_due.size() == 0) begin
          flag_mismatch($sformatf("result %0d arrived with nothing pending", result_no));
        end else begin
          due = results_due.pop_front();
          check_field("process_id", rrqs_pkg::TIME_W'(rsp_ch.process_id),
                      rrqs_pkg::TIME_W'(due.process_id));
          check_field("status", rrqs_pkg::TIME_W'(rsp_ch.status),
                      rrqs_pkg::TIME_W'(due.status));
          check_field("ran_for", rrqs_pkg::TIME_W'(rsp_ch.ran_for),
                      rrqs_pkg::TIME_W'(due.ran_for));
          check_field("waited_now", rsp_ch.waited_now, due.waited_now);
          check_field("process_wait", rsp_ch.process_wait, due.process_wait);
          check_field("clock_now", rsp_ch.clock_now, due.clock_now);
          check_field("total_wait", rsp_ch.total_wait, due.total_wait);
          check_field("finished_count", rrqs_pkg::TIME_W'(rsp_ch.finished_count),
                      rrqs_pkg::TIME_W'(due.finished_count));
          check_field("completed", rrqs_pkg::TIME_W'(rsp_ch.completed),
                      rrqs_pkg::TIME_W'(due.completed));
        end
        result_no++;
      end
      if (req_ch.valid && req_ch.ready) begin
        seen_rq = '{req_type: req_ch.req_type, burst: req_ch.burst,
                    prio: req_ch.priority_req};
        results_due.push_back(schedule_step(seen_rq));
        taken++;
      end
      if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
        stall_cycles = 0;
      end else begin
        stall_cycles++;
      end
    end
    in_taken <= (rst_n === 1'b1) && req_ch.valid && req_ch.ready;
  end

  initial begin : watchdog
    wait (stall_cycles >= STALL_LIMIT);
    $display("round_robin_ready_queue_scheduler_core test failed");
    $finish;
  end

  initial begin : stimulus
    int                           ph;
    logic [rrqs_pkg::BURST_W-1:0] q;
    logic                         rtc;
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    req_ch.valid = 1'b0;
    req_ch.req_type = rrqs_pkg::REQ_INSERT;
    req_ch.burst = '0;
    req_ch.priority_req = '0;
    rsp_ch.ready = 1'b0;
    in_taken = 1'b0;
    idling = 1'b1;
    issued = 0;
    taken = 0;
    result_no = 0;
    mismatches = 0;
    stall_cycles = 0;
    src_gap = 0;
    sink_gap = 0;
    head_m = 0;
    count_m = 0;
    next_id_m = rrqs_pkg::FIRST_ID;
    clock_m = '0;
    wait_sum_m = '0;
    done_m = '0;
    quantum_m = rrqs_pkg::QUANTUM_RST;
    rtc_m = 1'b0;
    repeat (6) @(negedge clk);
    rst_n <= 1'b1;

    // Directed: empty dispatch, head insert, bad priorities, zero and max bursts
    push_req(rrqs_pkg::REQ_DISPATCH, '1, '1);
    push_req(rrqs_pkg::REQ_INSERT, '0, rrqs_pkg::PRIO_NORMAL);
    push_req(rrqs_pkg::REQ_INSERT, '1, rrqs_pkg::PRIO_LOW);
    push_req(rrqs_pkg::REQ_INSERT, 16'd12, rrqs_pkg::PRIO_HIGH);
    push_req(rrqs_pkg::REQ_INSERT, 16'd7, 4'd0);
    push_req(rrqs_pkg::REQ_INSERT, 16'd7, 4'd15);
    repeat (6) push_req(rrqs_pkg::REQ_DISPATCH, '0, '0);
    // fill the ring, then hit it while full
    for (ph = 0; ph < rrqs_pkg::QUEUE_DEPTH - 1; ph++) begin
      push_req(rrqs_pkg::REQ_INSERT, rrqs_pkg::BURST_W'(ph * 3),
               (ph % 3 == 0) ? rrqs_pkg::PRIO_HIGH :
               (ph % 3 == 1) ? rrqs_pkg::PRIO_NORMAL : rrqs_pkg::PRIO_LOW);
    end
    push_req(rrqs_pkg::REQ_INSERT, 16'd9, rrqs_pkg::PRIO_NORMAL);
    push_req(rrqs_pkg::REQ_INSERT, 16'd9, rrqs_pkg::PRIO_HIGH);
    push_req(rrqs_pkg::REQ_INSERT, 16'd9, 4'd3);

    for (ph = 0; ph < 8; ph++) begin
      case (ph)
        0:       begin q = 16'd1;                                    rtc = 1'b0; end
        1:       begin q = '1;                                       rtc = 1'b0; end
        2:       begin q = '0;                                       rtc = 1'b0; end
        3:       begin q = rrqs_pkg::BURST_W'($urandom_range(2, 12)); rtc = 1'b0; end
        4:       begin q = rrqs_pkg::BURST_W'($urandom);              rtc = 1'b1; end
        5:       begin q = 16'd3;                                    rtc = 1'b1; end
        6:       begin q = rrqs_pkg::BURST_W'($urandom_range(1, 40)); rtc = 1'b0; end
        default: begin q = '1;                                       rtc = 1'b1; end
      endcase
      wait_drained();
      repeat (4) @(negedge clk);
      write_settings(q, rtc);
      idling = ($urandom_range(0, 3) != 0);
      random_phase(PHASE_ITEMS);
    end

    // Closing run of max bursts with no idling, run to completion.
    wait_drained();
    repeat (4) @(negedge clk);
    write_settings(rrqs_pkg::BURST_W'($urandom), 1'b1);
    idling = 1'b0;
    repeat (rrqs_pkg::QUEUE_DEPTH) push_req(rrqs_pkg::REQ_DISPATCH, '0, '0);
    repeat (12) push_req(rrqs_pkg::REQ_INSERT, '1, rrqs_pkg::PRIO_NORMAL);
    repeat (TAIL_PAIRS) begin
      push_req(rrqs_pkg::REQ_INSERT, '1, rrqs_pkg::PRIO_NORMAL);
      push_req(rrqs_pkg::REQ_DISPATCH, '0, '0);
    end
    repeat (4) push_req(rrqs_pkg::REQ_DISPATCH, '0, '0);
    push_req(rrqs_pkg::REQ_INSERT, 16'd1, rrqs_pkg::PRIO_HIGH);
    push_req(rrqs_pkg::REQ_DISPATCH, '0, '0);

    wait_drained();
    repeat (8) @(posedge clk);
    if (mismatches == 0 && results_due.size() == 0) begin
      $display("round_robin_ready_queue_scheduler_core test passed");
    end else begin
      $display("round_robin_ready_queue_scheduler_core test failed");
    end
    $finish;
  end

endmodule
